>>> design/mat4_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mat4_pkg
// Shared types for the matrix add / subtract / multiply unit: operation
// codes and the command word from the controller to the datapath.
// ---------------------------------------------------------------------------
package mat4_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_t;

  // tag that travels with each read beat down the datapath pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last_term;
    logic last_cell;
    logic mul;
    logic sub;
  } tag_t;

  typedef struct packed {
    logic wr;
    tag_t tag;
  } cmd_t;

endpackage

>>> design/matrix4_add_sub_multiply_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix4_add_sub_multiply_unit
// DIM x DIM signed fixed-point matrix add, subtract or multiply with
// saturation, results streamed in row-major order.
// ---------------------------------------------------------------------------
//  channel   dir  signals                                   beat taken when
//  operand   in   start, busy, left_value, right_value      start && !busy
//  result    out  result_strobe, result_value, last, sat.   result_strobe
//  config    in   cfg_write, cfg_data                       cfg_write
//
//  Loading takes one cycle per beat, DIM*DIM beats. After the last beat busy
//  is high while the sequencer issues one store read per cycle: one read per
//  result cell for add or subtract, one per inner term for multiply. Each
//  result beat passes the store read, the partial products or sum, the
//  product, its magnitude, the clipped term and the accumulator registers;
//  results stream in order, one a cycle for add or subtract, one per cell
//  for multiply. Reset is synchronous and clears control state only. The
//  receiver cannot stall.
// ---------------------------------------------------------------------------
module matrix4_add_sub_multiply_unit #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_data,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] left_value,
  input  logic signed [WORD_BITS-1:0] right_value,
  output logic                        result_strobe,
  output logic signed [WORD_BITS-1:0] result_value,
  output logic                        last,
  output logic                        saturated
);

  localparam int ADDR_W = $clog2(DIM * DIM);

  logic [1:0]          operation;
  mat4_pkg::cmd_t      cmd;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr_l;
  logic [ADDR_W-1:0]   rd_addr_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= mat4_pkg::OP_ADD;
    end else if (cfg_write) begin
      operation <= cfg_data;
    end
  end

  mat4_ctrl #(.DIM(DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .busy      (busy),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_l (rd_addr_l),
    .rd_addr_r (rd_addr_r)
  );

  mat4_datapath #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_addr_l     (rd_addr_l),
    .rd_addr_r     (rd_addr_r),
    .left_value    (left_value),
    .right_value   (right_value),
    .result_strobe (result_strobe),
    .result_value  (result_value),
    .last          (last),
    .saturated     (saturated)
  );

`ifndef SYNTHESIS
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an operand beat");

  a_last_strobed: assert property (@(posedge clk) disable iff (rst)
    last && result_strobe |=> !result_strobe)
    else $error("result beat right after the last element");

  a_no_load_while_issue: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.wr)
    else $error("store write during issue phase");

  a_issue_only_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.tag.valid |-> busy)
    else $error("read issued while idle");
`endif

endmodule

>>> design/mat4_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mat4_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module mat4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/mat4_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mat4_ctrl
// Sequencer: counts loaded elements, then walks the result cells (and the
// inner index for multiply) issuing one store read per cycle.
// ---------------------------------------------------------------------------
module mat4_ctrl #(
  parameter int DIM = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    operation,
  output logic                          busy,
  output mat4_pkg::cmd_t                cmd,
  output logic [$clog2(DIM*DIM)-1:0]    wr_addr,
  output logic [$clog2(DIM*DIM)-1:0]    rd_addr_l,
  output logic [$clog2(DIM*DIM)-1:0]    rd_addr_r
);

  localparam int CELLS  = DIM * DIM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W  = $clog2(DIM);

  typedef enum logic {
    S_LOAD,
    S_ISSUE
  } state_t;

  state_t                state;
  logic [ADDR_W-1:0]     load_count;
  logic [IDX_W-1:0]      row;
  logic [IDX_W-1:0]      col;
  logic [IDX_W-1:0]      k;
  mat4_pkg::op_t         op_reg;
  logic                  mul_op;
  logic                  sub_op;
  logic                  k_end;
  logic                  col_end;
  logic                  row_end;
  logic                  term_end;

  always_comb begin
    case (op_reg)
      mat4_pkg::OP_ADD: begin
        mul_op = 1'b0;
        sub_op = 1'b0;
      end
      mat4_pkg::OP_SUB: begin
        mul_op = 1'b0;
        sub_op = 1'b1;
      end
      default: begin
        mul_op = 1'b1;
        sub_op = 1'b0;
      end
    endcase
  end

  assign k_end    = (k == IDX_W'(DIM - 1));
  assign col_end  = (col == IDX_W'(DIM - 1));
  assign row_end  = (row == IDX_W'(DIM - 1));
  assign term_end = !mul_op || k_end;

  assign wr_addr   = load_count;
  assign rd_addr_l = mul_op ? ADDR_W'(row * DIM + k) : ADDR_W'(row * DIM + col);
  assign rd_addr_r = mul_op ? ADDR_W'(k * DIM + col) : ADDR_W'(row * DIM + col);

  always_comb begin
    cmd.wr             = start && !busy;
    cmd.tag.valid      = (state == S_ISSUE);
    cmd.tag.first      = !mul_op || (k == '0);
    cmd.tag.last_term  = term_end;
    cmd.tag.last_cell  = term_end && col_end && row_end;
    cmd.tag.mul        = mul_op;
    cmd.tag.sub        = sub_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      busy       <= 1'b0;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      k          <= '0;
      op_reg     <= mat4_pkg::OP_ADD;
    end else begin
      case (state)
        S_LOAD: begin
          if (start) begin
            if (load_count == ADDR_W'(CELLS - 1)) begin
              load_count <= '0;
              row        <= '0;
              col        <= '0;
              k          <= '0;
              op_reg     <= mat4_pkg::op_t'(operation);
              state      <= S_ISSUE;
              busy       <= 1'b1;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        S_ISSUE: begin
          if (!term_end) begin
            k <= k + 1'b1;
          end else begin
            k <= '0;
            if (!col_end) begin
              col <= col + 1'b1;
            end else begin
              col <= '0;
              if (!row_end) begin
                row <= row + 1'b1;
              end else begin
                row   <= '0;
                state <= S_LOAD;
                busy  <= 1'b0;
              end
            end
          end
        end
        default: begin
          state <= S_LOAD;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> design/mat4_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mat4_datapath
// Operand stores, split multiplier, rounding and clipping, accumulator and
// result register, in pipeline order after the registered store reads.
// ---------------------------------------------------------------------------
module mat4_datapath #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mat4_pkg::cmd_t                cmd,
  input  logic [$clog2(DIM*DIM)-1:0]    wr_addr,
  input  logic [$clog2(DIM*DIM)-1:0]    rd_addr_l,
  input  logic [$clog2(DIM*DIM)-1:0]    rd_addr_r,
  input  logic signed [WORD_BITS-1:0]   left_value,
  input  logic signed [WORD_BITS-1:0]   right_value,
  output logic                          result_strobe,
  output logic signed [WORD_BITS-1:0]   result_value,
  output logic                          last,
  output logic                          saturated
);

  localparam int W     = WORD_BITS;
  localparam int PW    = 2 * W;
  localparam int LO_W  = W / 2;
  localparam int HI_W  = W - LO_W;
  localparam int PL_W  = W + LO_W + 1;
  localparam int PH_W  = W + HI_W;
  localparam int ACC_W = W + $clog2(DIM) + 1;

  localparam logic [PW-1:0] ONE     = {{(PW-1){1'b0}}, 1'b1};
  localparam logic [PW-1:0] NEG_LIM = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] POS_LIM = NEG_LIM - ONE;
  localparam logic [PW-1:0] HALF    =
    (FRAC_BITS > 0) ? (ONE << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;
  localparam logic [W-1:0]  WMAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN    = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0]   rd_l;
  logic signed [W-1:0]   rd_r;
  mat4_pkg::tag_t        t1, t2, t3, t4, t5, t6;

  logic signed [PL_W-1:0] pp_lo;
  logic signed [PH_W-1:0] pp_hi;
  logic [W:0]             sd2, sd3, sd4;
  logic [PW-1:0]          prod;
  logic [PW-1:0]          mag;
  logic                   neg4;
  logic [W-1:0]           term;
  logic                   term_flag;
  logic [ACC_W-1:0]       acc;
  logic                   acc_flag;

  logic [PW-1:0]          rsum;
  logic [PW-1:0]          shifted;
  logic [PW-1:0]          lim;
  logic [W-1:0]           m_term;
  logic                   m_flag;
  logic [W-1:0]           s_term;
  logic                   s_flag;
  logic                   acc_fits;

  mat4_ram #(.WIDTH(W), .DEPTH(DIM * DIM)) u_left_store (
    .clk     (clk),
    .wr_en   (cmd.wr),
    .wr_addr (wr_addr),
    .wr_data (left_value),
    .rd_addr (rd_addr_l),
    .rd_data (rd_l)
  );

  mat4_ram #(.WIDTH(W), .DEPTH(DIM * DIM)) u_right_store (
    .clk     (clk),
    .wr_en   (cmd.wr),
    .wr_addr (wr_addr),
    .wr_data (right_value),
    .rd_addr (rd_addr_r),
    .rd_data (rd_r)
  );

  // round the product half away from zero, then clip; clip the sum or difference
  always_comb begin
    rsum    = mag + HALF;
    shifted = rsum >> FRAC_BITS;
    lim     = neg4 ? NEG_LIM : POS_LIM;
    if (shifted > lim) begin
      m_term = neg4 ? WMIN : WMAX;
      m_flag = 1'b1;
    end else begin
      m_term = neg4 ? -shifted[W-1:0] : shifted[W-1:0];
      m_flag = 1'b0;
    end
    if (sd4[W] != sd4[W-1]) begin
      s_term = sd4[W] ? WMIN : WMAX;
      s_flag = 1'b1;
    end else begin
      s_term = sd4[W-1:0];
      s_flag = 1'b0;
    end
  end

  assign acc_fits = (&acc[ACC_W-1:W-1]) || !(|acc[ACC_W-1:W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      t1            <= '0;
      t2            <= '0;
      t3            <= '0;
      t4            <= '0;
      t5            <= '0;
      t6            <= '0;
      result_strobe <= 1'b0;
    end else begin
      t1            <= cmd.tag;
      t2            <= t1;
      t3            <= t2;
      t4            <= t3;
      t5            <= t4;
      t6            <= t5;
      result_strobe <= t6.valid && t6.last_term;
    end
  end

  always_ff @(posedge clk) begin
    pp_lo <= rd_l * $signed({1'b0, rd_r[LO_W-1:0]});
    pp_hi <= rd_l * $signed(rd_r[W-1:LO_W]);
    sd2   <= t1.sub ? {rd_l[W-1], rd_l} - {rd_r[W-1], rd_r}
                    : {rd_l[W-1], rd_l} + {rd_r[W-1], rd_r};

    prod  <= ({{LO_W{pp_hi[PH_W-1]}}, pp_hi} << LO_W)
           + {{(HI_W-1){pp_lo[PL_W-1]}}, pp_lo};
    sd3   <= sd2;

    neg4  <= prod[PW-1];
    mag   <= prod[PW-1] ? -prod : prod;
    sd4   <= sd3;

    term      <= t4.mul ? m_term : s_term;
    term_flag <= t4.mul ? m_flag : s_flag;

    if (t5.valid) begin
      if (t5.first) begin
        acc      <= {{(ACC_W-W){term[W-1]}}, term};
        acc_flag <= term_flag;
      end else begin
        acc      <= acc + {{(ACC_W-W){term[W-1]}}, term};
        acc_flag <= acc_flag | term_flag;
      end
    end

    if (t6.valid && t6.last_term) begin
      result_value <= acc_fits ? acc[W-1:0] : (acc[ACC_W-1] ? WMIN : WMAX);
      saturated    <= acc_flag | !acc_fits;
      last         <= t6.last_cell;
    end
  end

endmodule
